// ----- src/salc_pkg.sv -----
package salc_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_ACTIVE_WAYS = 2'd0;
	localparam logic [1:0] REG_SET_BITS    = 2'd1;
	localparam logic [1:0] REG_BLOCK_SIZE  = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 4;

	// Block size codes.
	localparam logic [1:0] BLK_4B  = 2'd0;
	localparam logic [1:0] BLK_8B  = 2'd1;
	localparam logic [1:0] BLK_16B = 2'd2;

	// Offset widths that go with each block size.
	localparam logic [2:0] OFF_4B  = 3'd2;
	localparam logic [2:0] OFF_8B  = 3'd3;
	localparam logic [2:0] OFF_16B = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [3:0] RST_ACTIVE_WAYS = 4'd2;
	localparam logic [3:0] RST_SET_BITS    = 4'd4;
	localparam logic [1:0] RST_BLOCK_SIZE  = BLK_16B;

	typedef struct packed {
		logic [3:0] active_ways;
		logic [3:0] set_index_bits;
		logic [1:0] block_size_code;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic lookup;
	} cmd_t;

endpackage

// ----- src/salc_ctrl.sv -----
module salc_ctrl
	import salc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_LOOKUP = 1'b1;

	logic state_q;
	logic done_q;

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.lookup  = (state_q == ST_LOOKUP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.lookup;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == ST_LOOKUP);
	assign done = done_q;

endmodule

// ----- src/salc_lru.sv -----
module salc_lru
	import salc_pkg::*;
#(
	parameter int MAX_WAYS = 8,
	parameter int TAG_W    = 30,
	parameter int AGE_W    = 3,
	parameter int WAY_W    = 3
) (
	input  logic [MAX_WAYS-1:0][TAG_W-1:0] tags,
	input  logic [MAX_WAYS-1:0]            valids,
	input  logic [MAX_WAYS-1:0][AGE_W-1:0] ages,
	input  logic [MAX_WAYS-1:0]            active,
	input  logic [TAG_W-1:0]               tag,
	output logic                           hit,
	output logic [WAY_W-1:0]               way,
	output logic [MAX_WAYS-1:0]            new_valids,
	output logic [MAX_WAYS-1:0][AGE_W-1:0] new_ages
);

	localparam logic [AGE_W-1:0] AGE_TOP   = AGE_W'(MAX_WAYS - 1);
	localparam logic [AGE_W:0]   RANK_FILL = (AGE_W + 1)'(MAX_WAYS);

	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] empty;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    empty_way;
	logic [WAY_W-1:0]    lru_way;
	logic                has_empty;
	logic [AGE_W:0]      old_rank;

	always_comb begin
		match     = '0;
		empty     = '0;
		hit_way   = '0;
		empty_way = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			match[i] = active[i] && valids[i] && (tags[i] == tag);
			empty[i] = active[i] && !valids[i];
		end
		// Scanning downwards leaves the lowest-numbered way selected.
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (match[i]) hit_way = WAY_W'(i);
			if (empty[i]) empty_way = WAY_W'(i);
		end
		hit       = |match;
		has_empty = |empty;
	end

	// Oldest way; a strict compare keeps the lowest way among equal ranks.
	always_comb begin
		lru_way = '0;
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (active[i] && (ages[i] > ages[lru_way])) lru_way = WAY_W'(i);
		end
	end

	always_comb begin
		if (hit) begin
			way      = hit_way;
			old_rank = {1'b0, ages[hit_way]};
		end else if (has_empty) begin
			way      = empty_way;
			old_rank = RANK_FILL;
		end else begin
			way      = lru_way;
			old_rank = {1'b0, ages[lru_way]};
		end
	end

	always_comb begin
		new_ages   = ages;
		new_valids = valids;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (active[i] && valids[i] && (WAY_W'(i) != way) &&
			    ({1'b0, ages[i]} < old_rank) && (ages[i] < AGE_TOP)) begin
				new_ages[i] = ages[i] + AGE_W'(1);
			end
		end
		new_ages[way]   = '0;
		new_valids[way] = 1'b1;
	end

endmodule

// ----- src/salc_dpath.sv -----
module salc_dpath
	import salc_pkg::*;
#(
	parameter int MAX_WAYS   = 8,
	parameter int MAX_SETS   = 256,
	parameter int ADDR_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  cfg_t        cfg,
	input  logic [31:0] address,
	output logic        hit,
	output logic [2:0]  way,
	output logic [31:0] hits_so_far,
	output logic [31:0] accesses_so_far
);

	localparam int AW           = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
	localparam int TAG_W        = AW - 2;
	localparam int AGE_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_W        = AGE_W;
	localparam int SET_W        = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int MAX_SET_BITS = $clog2(MAX_SETS + 1) - 1;
	localparam logic [31:0] ADDR_MASK = 32'((64'(1) << AW) - 64'(1));

	logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem   [MAX_SETS];
	logic [MAX_WAYS-1:0]            valid_mem [MAX_SETS];
	logic [MAX_WAYS-1:0][AGE_W-1:0] age_mem   [MAX_SETS];
	logic [MAX_SETS-1:0]            row_valid_q;

	logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_s1;
	logic [MAX_WAYS-1:0]            valid_row_s1;
	logic [MAX_WAYS-1:0][AGE_W-1:0] age_row_s1;
	logic                           row_ok_s1;
	logic [TAG_W-1:0]               tag_s1;
	logic [SET_W-1:0]               set_s1;

	logic [31:0]      addr_m;
	logic [2:0]       off_bits;
	logic [3:0]       set_bits;
	logic [31:0]      set_field;
	logic [31:0]      tag_field;
	logic [SET_W-1:0] set_mask;
	logic [SET_W-1:0] set_idx;

	logic [4:0]                     ways_eff;
	logic [MAX_WAYS-1:0]            active;
	logic [MAX_WAYS-1:0]            valid_eff;
	logic [MAX_WAYS-1:0][AGE_W-1:0] age_eff;
	logic                           lk_hit;
	logic [WAY_W-1:0]               lk_way;
	logic [MAX_WAYS-1:0]            new_valids;
	logic [MAX_WAYS-1:0][AGE_W-1:0] new_ages;
	logic [MAX_WAYS-1:0][TAG_W-1:0] new_tags;

	logic        hit_q;
	logic [2:0]  way_q;
	logic [31:0] hit_cnt_q;
	logic [31:0] acc_cnt_q;

	// Address split under the current block size and set count.
	always_comb begin
		addr_m = address & ADDR_MASK;
		case (cfg.block_size_code)
			BLK_4B:  off_bits = OFF_4B;
			BLK_8B:  off_bits = OFF_8B;
			BLK_16B: off_bits = OFF_16B;
			default: off_bits = OFF_16B;
		endcase
		if (cfg.set_index_bits > 4'(MAX_SET_BITS)) set_bits = 4'(MAX_SET_BITS);
		else set_bits = cfg.set_index_bits;
		set_mask  = ~({SET_W{1'b1}} << set_bits);
		set_field = addr_m >> off_bits;
		tag_field = addr_m >> ({2'b00, off_bits} + {1'b0, set_bits});
		set_idx   = set_field[SET_W-1:0] & set_mask;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_row_s1   <= tag_mem[set_idx];
			valid_row_s1 <= valid_mem[set_idx];
			age_row_s1   <= age_mem[set_idx];
			row_ok_s1    <= row_valid_q[set_idx];
			tag_s1       <= tag_field[TAG_W-1:0];
			set_s1       <= set_idx;
		end
	end

	// A set that has never been written reads as all ways invalid and of rank zero.
	always_comb begin
		if (cfg.active_ways == 4'd0) ways_eff = 5'd1;
		else if ({1'b0, cfg.active_ways} > 5'(MAX_WAYS)) ways_eff = 5'(MAX_WAYS);
		else ways_eff = {1'b0, cfg.active_ways};
		for (int i = 0; i < MAX_WAYS; i++) begin
			active[i] = (5'(i) < ways_eff);
		end
		valid_eff = row_ok_s1 ? valid_row_s1 : '0;
		age_eff   = row_ok_s1 ? age_row_s1 : '0;
	end

	salc_lru #(
		.MAX_WAYS (MAX_WAYS),
		.TAG_W    (TAG_W),
		.AGE_W    (AGE_W),
		.WAY_W    (WAY_W)
	) u_lru (
		.tags       (tag_row_s1),
		.valids     (valid_eff),
		.ages       (age_eff),
		.active     (active),
		.tag        (tag_s1),
		.hit        (lk_hit),
		.way        (lk_way),
		.new_valids (new_valids),
		.new_ages   (new_ages)
	);

	always_comb begin
		new_tags = tag_row_s1;
		if (!lk_hit) new_tags[lk_way] = tag_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			tag_mem[set_s1]   <= new_tags;
			valid_mem[set_s1] <= new_valids;
			age_mem[set_s1]   <= new_ages;
			hit_q             <= lk_hit;
			way_q             <= 3'(lk_way);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			hit_cnt_q   <= '0;
			acc_cnt_q   <= '0;
		end else if (cmd.lookup) begin
			row_valid_q[set_s1] <= 1'b1;
			if (lk_hit && (hit_cnt_q != '1)) hit_cnt_q <= hit_cnt_q + 32'd1;
			if (acc_cnt_q != '1) acc_cnt_q <= acc_cnt_q + 32'd1;
		end
	end

	assign hit             = hit_q;
	assign way             = way_q;
	assign hits_so_far     = hit_cnt_q;
	assign accesses_so_far = acc_cnt_q;

endmodule

// ----- src/set_assoc_lru_cache_tags.sv -----
// Tag store of a set-associative cache with true LRU replacement.
// Input beat: drive address and raise start; the beat is taken at a rising edge
// where start is high and busy is low. Each beat yields one result beat: done is
// high for exactly one cycle with hit, way, hits_so_far and accesses_so_far valid.
// The receiver cannot hold results off and must take them in that cycle.
// Sequence: the accepting edge reads the set's row of the tag and age memory into
// registers; the lookup state then compares, picks the way, writes the row back
// and registers the result together with done. Busy is high in the lookup state,
// so a new address is taken only once the read-modify-write of the previous
// address's row has finished.
// Configuration: cfg_we, cfg_index and cfg_data write a register at a rising
// edge, to be used only while no access is in flight. Index 0 is active_ways,
// 1 is set_index_bits, 2 is block_size_code; other indexes are ignored.
// Reset: the registers return to 2 ways, 16 sets and 16-byte blocks, both totals
// clear, and every set reads as empty straight away through a per-set valid
// flop, so no clearing pass is needed and start may be raised at once.
module set_assoc_lru_cache_tags
	import salc_pkg::*;
#(
	parameter int MAX_WAYS   = 8,
	parameter int MAX_SETS   = 256,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [31:0]            address,
	output logic                   done,
	output logic                   hit,
	output logic [2:0]             way,
	output logic [31:0]            hits_so_far,
	output logic [31:0]            accesses_so_far,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_ways     <= RST_ACTIVE_WAYS;
			cfg_q.set_index_bits  <= RST_SET_BITS;
			cfg_q.block_size_code <= RST_BLOCK_SIZE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_WAYS: cfg_q.active_ways     <= cfg_data;
				REG_SET_BITS:    cfg_q.set_index_bits  <= cfg_data;
				REG_BLOCK_SIZE:  cfg_q.block_size_code <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	salc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	salc_dpath #(
		.MAX_WAYS   (MAX_WAYS),
		.MAX_SETS   (MAX_SETS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg_q),
		.address         (address),
		.hit             (hit),
		.way             (way),
		.hits_so_far     (hits_so_far),
		.accesses_so_far (accesses_so_far)
	);

endmodule

// ----- verif/tb_set_assoc_lru_cache_tags.sv -----
module tb_set_assoc_lru_cache_tags
	import salc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WAYS     = 8;
	localparam int MAX_SETS     = 256;
	localparam int LINES        = MAX_WAYS * MAX_SETS;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DIR_ROWS     = 25;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 65;
	localparam int SETTLE       = 4;

	// Index 3 has no register behind it and block code 3 has no size of its own.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [1:0] BLK_UNUSED = 2'd3;

	typedef struct packed {
		logic        hit;
		logic [2:0]  way;
		logic [31:0] hits;
		logic [31:0] accesses;
	} lookup_res_t;

	typedef enum logic {ROW_ACC, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] addr;
		logic        typed;
		lookup_res_t exp;
		logic [3:0]  ways;
		logic [3:0]  sbits;
		logic [1:0]  blk;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] address;
	logic        done;
	logic        hit;
	logic [2:0]  way;
	logic [31:0] hits_so_far;
	logic [31:0] accesses_so_far;
	logic        cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Shadow of the tag store and registers, kept in step with accepted beats.
	bit [29:0]   line_tag [LINES];
	bit          line_valid [LINES];
	bit [2:0]    line_age [LINES];
	logic [31:0] hit_total;
	logic [31:0] access_total;
	logic [3:0]  cfg_ways;
	logic [3:0]  cfg_sbits;
	logic [1:0]  cfg_blk;

	lookup_res_t lookups_due [$];
	int          fails;
	int          cycles;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_ACC, 32'h0000_0000, 1'b1, '{1'b0, 3'd0, 32'd0, 32'd1}, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h0000_000C, 1'b1, '{1'b1, 3'd0, 32'd1, 32'd2}, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h0000_0100, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h0000_0200, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 32'd1, 32'd5}, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'hFFFF_FFF0, 1'b1, '{1'b1, 3'd0, 32'd2, 32'd6}, 4'd0, 4'd0, 2'd0},
		'{ROW_CFG, 32'h0000_0000, 1'b0, '0, 4'd8, 4'd0, BLK_4B},
		'{ROW_ACC, 32'h0000_0000, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h0000_0004, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h0000_0008, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h0000_000C, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h8000_0000, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h4000_0000, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h2000_0000, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h1000_0000, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h0000_0004, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'hFFFF_FFFC, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_CFG, 32'h0000_0000, 1'b0, '0, 4'd0, 4'd15, BLK_UNUSED},
		'{ROW_ACC, 32'h0000_0FF0, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h0000_1FF0, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h0000_0FF0, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_CFG, 32'h0000_0000, 1'b0, '0, 4'd15, 4'd8, BLK_8B},
		'{ROW_ACC, 32'h1234_5678, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'h1234_5678, 1'b0, '0, 4'd0, 4'd0, 2'd0},
		'{ROW_ACC, 32'hEDCB_A987, 1'b0, '0, 4'd0, 4'd0, 2'd0}
	};

	set_assoc_lru_cache_tags dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.address         (address),
		.done            (done),
		.hit             (hit),
		.way             (way),
		.hits_so_far     (hits_so_far),
		.accesses_so_far (accesses_so_far),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Way w becomes most recent; every other valid way younger than its old rank ages.
	function automatic void age_touch(input int base, input int ways, input int w,
	                                  input int old_rank);
		for (int i = 0; i < ways; i++) begin
			if (i == w || !line_valid[base + i])
				continue;
			if (line_age[base + i] < old_rank && line_age[base + i] < MAX_WAYS - 1)
				line_age[base + i]++;
		end
		line_age[base + w] = '0;
	endfunction

	function automatic lookup_res_t lookup_and_update(input logic [31:0] a);
		int          ways;
		int          sbits;
		int          off;
		int          base;
		int          w;
		logic [31:0] tag;
		logic        found;
		lookup_res_t r;
		ways = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
		sbits = cfg_sbits;
		while (sbits > 0 && (1 << sbits) > MAX_SETS)
			sbits--;
		off = 2 + ((cfg_blk > BLK_16B) ? 2 : int'(cfg_blk));
		base = int'((a >> off) & ((32'd1 << sbits) - 1)) * MAX_WAYS;
		tag = a >> (off + sbits);
		found = 1'b0;
		w = 0;
		for (int i = 0; i < ways; i++) begin
			if (!found && line_valid[base + i] && line_tag[base + i] == tag[29:0]) begin
				found = 1'b1;
				w = i;
			end
		end
		r.hit = found;
		if (found) begin
			age_touch(base, ways, w, line_age[base + w]);
			if (hit_total != '1)
				hit_total++;
		end else begin
			for (int i = ways - 1; i >= 0; i--)
				if (!line_valid[base + i]) begin
					found = 1'b1;
					w = i;
				end
			if (found) begin
				age_touch(base, ways, w, MAX_WAYS);
			end else begin
				// Strictly greater keeps the lowest way among equal oldest ranks.
				w = 0;
				for (int i = 1; i < ways; i++)
					if (line_age[base + i] > line_age[base + w])
						w = i;
				age_touch(base, ways, w, line_age[base + w]);
			end
			line_tag[base + w] = tag[29:0];
			line_valid[base + w] = 1'b1;
		end
		if (access_total != '1)
			access_total++;
		r.way = w[2:0];
		r.hits = hit_total;
		r.accesses = access_total;
		return r;
	endfunction

	// Called just after a falling edge; returns just after the falling edge that
	// follows the accepting rising edge.
	task automatic put_access(input logic [31:0] a, input int gap, input logic typed,
	                          input lookup_res_t typed_res);
		lookup_res_t r;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		address <= a;
		do @(posedge clk); while (busy);
		r = lookup_and_update(a);
		if (typed)
			r = typed_res;
		lookups_due.push_back(r);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (lookups_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Writes all three registers and the spare index, with the enable held high throughout.
	task automatic write_config(input logic [3:0] ways, input logic [3:0] sbits,
	                            input logic [1:0] blk);
		logic [1:0] idx [4];
		logic [3:0] val [4];
		idx[0] = REG_ACTIVE_WAYS;
		idx[1] = REG_SET_BITS;
		idx[2] = REG_BLOCK_SIZE;
		idx[3] = REG_UNUSED;
		val[0] = ways;
		val[1] = sbits;
		val[2] = {2'b00, blk};
		val[3] = 4'($urandom_range(0, 15));
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			case (idx[k])
				REG_ACTIVE_WAYS: cfg_ways = val[k];
				REG_SET_BITS:    cfg_sbits = val[k];
				REG_BLOCK_SIZE:  cfg_blk = val[k][1:0];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		lookup_res_t e;
		if (arst_n && done) begin
			if (lookups_due.size() == 0) begin
				$error("result beat with no lookup outstanding");
				fails++;
			end else begin
				e = lookups_due.pop_front();
				if (hit !== e.hit) begin
					$error("hit: expected %0d, actual %0d", e.hit, hit);
					fails++;
				end
				if (way !== e.way) begin
					$error("way: expected %0d, actual %0d", e.way, way);
					fails++;
				end
				if (hits_so_far !== e.hits) begin
					$error("hits_so_far: expected %0d, actual %0d", e.hits, hits_so_far);
					fails++;
				end
				if (accesses_so_far !== e.accesses) begin
					$error("accesses_so_far: expected %0d, actual %0d", e.accesses,
					       accesses_so_far);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] pool [16];
		logic [31:0] phase_low;
		logic [31:0] a;
		logic [3:0]  pw;
		logic [3:0]  ps;
		logic [1:0]  pb;
		int          pick;
		int          k;
		int          gap;
		logic        no_idle;
		start = 1'b0;
		address = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		fails = 0;
		cycles = 0;
		hit_total = '0;
		access_total = '0;
		cfg_ways = RST_ACTIVE_WAYS;
		cfg_sbits = RST_SET_BITS;
		cfg_blk = RST_BLOCK_SIZE;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				wait_drained();
				write_config(dir_rows[r].ways, dir_rows[r].sbits, dir_rows[r].blk);
			end else begin
				put_access(dir_rows[r].addr, $urandom_range(0, 17), dir_rows[r].typed,
				           dir_rows[r].exp);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin pw = 4'd1;  ps = 4'd0;  pb = BLK_4B;     end
				1: begin pw = 4'd8;  ps = 4'd8;  pb = BLK_16B;    end
				2: begin pw = 4'd0;  ps = 4'd15; pb = BLK_UNUSED; end
				3: begin pw = 4'd15; ps = 4'd9;  pb = BLK_8B;     end
				4: begin pw = 4'd8;  ps = 4'd1;  pb = BLK_4B;     end
				default: begin
					pw = 4'($urandom_range(0, 15));
					ps = 4'($urandom_range(0, 15));
					pb = 2'($urandom_range(0, 3));
				end
			endcase
			wait_drained();
			write_config(pw, ps, pb);
			// A working set crowded into a handful of sets, so that hits and evictions
			// both come often.
			phase_low = $urandom & 32'h0000_0FFF;
			for (int i = 0; i < 16; i++)
				pool[i] = ($urandom & 32'hFFFF_F000) |
				          (phase_low ^ (32'($urandom_range(0, 3)) << 4));
			no_idle = (phase % 3 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				k = $urandom_range(0, 15);
				if (pick < 65) begin
					a = pool[k] ^ 32'($urandom_range(0, 3));
				end else if (pick < 90) begin
					pool[k] = pool[k] ^ ($urandom & 32'hFFFF_F000);
					a = pool[k];
				end else begin
					a = $urandom;
				end
				gap = no_idle ? 0 : $urandom_range(0, 17);
				put_access(a, gap, 1'b0, '0);
				if (phase == 2 && n == 30)
					wait_drained();
			end
		end

		wait_drained();
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/salc_pkg.sv
src/salc_ctrl.sv
src/salc_lru.sv
src/salc_dpath.sv
src/set_assoc_lru_cache_tags.sv
verif/tb_set_assoc_lru_cache_tags.sv
